@@ hw/rtl/y86f_pkg.sv @@
// y86f_pkg: types, codes and constants shared by the y86 fetch stage core
// no dependencies; imported by every module of the block except y86f_ram

package y86f_pkg;

  // item kind carried on in_tuser
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  // instruction codes the fetch logic looks at
  localparam logic [3:0] ICODE_CMOVXX = 4'h2;
  localparam logic [3:0] ICODE_IRMOVQ = 4'h3;
  localparam logic [3:0] ICODE_RMMOVQ = 4'h4;
  localparam logic [3:0] ICODE_MRMOVQ = 4'h5;
  localparam logic [3:0] ICODE_OPQ    = 4'h6;
  localparam logic [3:0] ICODE_JXX    = 4'h7;
  localparam logic [3:0] ICODE_CALL   = 4'h8;
  localparam logic [3:0] ICODE_RET    = 4'h9;
  localparam logic [3:0] ICODE_PUSHQ  = 4'hA;
  localparam logic [3:0] ICODE_POPQ   = 4'hB;
  localparam logic [3:0] REG_NONE     = 4'hF;

  // byte-interleaved instruction memory
  localparam int BANK_BITS   = 4;
  localparam int NUM_BANKS   = 16;
  localparam int FETCH_BYTES = 10;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // stream widths
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 272;

  // one input item
  typedef struct packed {
    op_t         op;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [3:0]  mem_icode;
    logic        mem_cond;
    logic [63:0] mem_vala;
    logic [3:0]  wb_icode;
    logic [63:0] wb_valm;
  } fetch_req_t;

  // item held while the bank reads are in flight
  typedef struct packed {
    logic        valid;
    logic        is_fetch;
    logic [63:0] pc;
  } stage_t;

  // one result item
  typedef struct packed {
    logic [63:0] fetch_pc;
    logic [3:0]  instr_code;
    logic [3:0]  instr_func;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [63:0] const_value;
    logic [63:0] next_seq_pc;
    logic [63:0] predicted_pc;
  } result_t;

  // instruction carries a register specifier byte
  function automatic logic has_regs(input logic [3:0] code);
    return code inside {ICODE_CMOVXX, ICODE_IRMOVQ, ICODE_RMMOVQ, ICODE_MRMOVQ,
                        ICODE_OPQ, ICODE_PUSHQ, ICODE_POPQ};
  endfunction

  // instruction carries an eight-byte constant
  function automatic logic has_const(input logic [3:0] code);
    return code inside {ICODE_IRMOVQ, ICODE_RMMOVQ, ICODE_MRMOVQ, ICODE_JXX, ICODE_CALL};
  endfunction

endpackage

@@ hw/rtl/y86_fetch_stage_core.sv @@
// y86_fetch_stage_core: top level of the y86-64 fetch stage over banked byte memory
// depends on y86f_pkg, y86f_front, y86f_back, y86f_queue (and y86f_ram below them)
//
// channel   dir  signals                        content
// in_       in   tvalid tready tdata tuser      load byte or fetch cycle feedback
// out_      out  tvalid tready tdata            one fetched instruction per item
//
// one item per cycle while in_tready is high; results pass the issue stage register
// and then the queue; the rate is set by the fetch pc loop: the prediction decoded
// from one cycle's registered bank reads addresses the sixteen memory banks for the
// next fetch; reset clears the held prediction and the queue; memory is not cleared
// in_tready falls once the queue entries plus the item in the issue stage reach four

module y86_fetch_stage_core
  import y86f_pkg::*;
#(
  parameter int MEM_BYTES = 4096  // power of two, at least 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // load_address[11:0] load_byte[19:12] mem_icode[23:20] mem_cond[24]
  // mem_vala[88:25] wb_icode[92:89] wb_valm[156:93] zero[159:157]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // fetch_pc[63:0] instr_code[67:64] instr_func[71:68] reg_a[75:72] reg_b[79:76]
  // const_value[143:80] next_seq_pc[207:144] predicted_pc[271:208]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  fetch_req_t                req;
  stage_t                    stage;
  logic [NUM_BANKS-1:0][7:0] bank_rd;
  logic                      accept;
  logic [63:0]               pred_now;
  logic                      res_valid;
  result_t                   res;
  result_t                   head;
  logic [QCNT_W-1:0]         q_cnt;
  logic [QCNT_W:0]           used;

  // unpack input transfer
  assign req = '{
    op:           op_t'(in_tuser),
    load_address: in_tdata[11:0],
    load_byte:    in_tdata[19:12],
    mem_icode:    in_tdata[23:20],
    mem_cond:     in_tdata[24],
    mem_vala:     in_tdata[88:25],
    wb_icode:     in_tdata[92:89],
    wb_valm:      in_tdata[156:93]
  };

  // credit: queue entries plus the item in the issue stage
  assign used      = {1'b0, q_cnt} + {{QCNT_W{1'b0}}, stage.valid};
  assign in_tready = (used < (QCNT_W + 1)'(QDEPTH));
  assign accept    = in_tvalid && in_tready;

  y86f_front #(
    .MEM_BYTES (MEM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req      (req),
    .pred_now (pred_now),
    .stage    (stage),
    .bank_rd  (bank_rd)
  );

  y86f_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .bank_rd   (bank_rd),
    .res_valid (res_valid),
    .res       (res),
    .pred_now  (pred_now)
  );

  y86f_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .pop_ready  (out_tready),
    .head_valid (out_tvalid),
    .head_data  (head),
    .count      (q_cnt)
  );

  // pack output transfer
  assign out_tdata = {head.predicted_pc, head.next_seq_pc, head.const_value,
                      head.reg_b, head.reg_a, head.instr_func, head.instr_code,
                      head.fetch_pc};

endmodule

@@ hw/rtl/y86f_ram.sv @@
// y86f_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module y86f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/y86f_front.sv @@
// y86f_front: fetch pc select, banked instruction memory and issue stage
// depends on y86f_pkg and y86f_ram

module y86f_front
  import y86f_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  fetch_req_t                    req,
  input  logic [63:0]                   pred_now,
  output stage_t                        stage,
  output logic [NUM_BANKS-1:0][7:0]     bank_rd
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int ROWS = MEM_BYTES / NUM_BANKS;
  localparam int RW   = (AW > BANK_BITS) ? AW - BANK_BITS : 1;

  logic [63:0]                    pc_sel;
  logic [AW-1:0]                  pc_mem;
  logic [AW-1:0]                  wr_addr;
  logic [RW-1:0]                  row_base;
  logic [RW-1:0]                  row_inc;
  logic [RW-1:0]                  wr_row;
  logic [NUM_BANKS-1:0][RW-1:0]   rd_row;
  logic [NUM_BANKS-1:0]           bank_we;
  logic                           is_load;

  logic                           valid_r;
  logic                           is_fetch_r;
  logic [63:0]                    pc_r;

  // fetch pc: mispredicted jump, then return, then prediction
  always_comb begin
    if (req.mem_icode == ICODE_JXX && !req.mem_cond) begin
      pc_sel = req.mem_vala;
    end else if (req.wb_icode == ICODE_RET) begin
      pc_sel = req.wb_valm;
    end else begin
      pc_sel = pred_now;
    end
  end

  // bank row addresses; banks below the start lane read the next row
  assign pc_mem   = AW'(pc_sel);
  assign row_base = RW'(pc_mem >> BANK_BITS);
  assign row_inc  = (ROWS == 1) ? '0 : RW'(row_base + 1'b1);

  // load write address, wrapped to memory size
  assign is_load = accept && (req.op == OP_LOAD);
  assign wr_addr = AW'(req.load_address);
  assign wr_row  = RW'(wr_addr >> BANK_BITS);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    assign rd_row[b]  = (BANK_BITS'(b) < pc_mem[BANK_BITS-1:0]) ? row_inc : row_base;
    assign bank_we[b] = is_load && (wr_addr[BANK_BITS-1:0] == BANK_BITS'(b));

    y86f_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (wr_row),
      .wdata (req.load_byte),
      .raddr (rd_row[b]),
      .rdata (bank_rd[b])
    );
  end

  // issue stage, lines up with the registered bank data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_fetch_r <= (req.op == OP_FETCH);
      pc_r       <= pc_sel;
    end
  end

  assign stage = '{valid: valid_r, is_fetch: is_fetch_r, pc: pc_r};

endmodule

@@ hw/rtl/y86f_back.sv @@
// y86f_back: instruction split, constant assembly and next pc prediction
// depends on y86f_pkg; takes the issue stage and bank data from y86f_front

module y86f_back
  import y86f_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  stage_t                    stage,
  input  logic [NUM_BANKS-1:0][7:0] bank_rd,
  output logic                      res_valid,
  output result_t                   res,
  output logic [63:0]               pred_now
);

  logic [7:0]  fb [FETCH_BYTES];
  logic [3:0]  code;
  logic [3:0]  func;
  logic        regs;
  logic        cst;
  logic [63:0] cval_raw;
  logic [63:0] cval;
  logic [3:0]  len;
  logic [63:0] next_pc;
  logic [63:0] pred;
  logic        fetch_done;

  logic [63:0] held_r;
  logic [63:0] held_nxt;

  // rotate bank outputs into instruction byte order
  always_comb begin
    for (int k = 0; k < FETCH_BYTES; k++) begin
      fb[k] = bank_rd[stage.pc[BANK_BITS-1:0] + BANK_BITS'(k)];
    end
  end

  // field split and little-endian constant
  assign code = fb[0][7:4];
  assign func = fb[0][3:0];
  assign regs = has_regs(code);
  assign cst  = has_const(code);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      cval_raw[8*j +: 8] = regs ? fb[j+2] : fb[j+1];
    end
  end

  assign cval    = cst ? cval_raw : '0;
  assign len     = 4'd1 + {3'd0, regs} + {cst, 3'd0};
  assign next_pc = stage.pc + 64'(len);
  assign pred    = (code == ICODE_JXX || code == ICODE_CALL) ? cval : next_pc;

  // result; a load gives all zeros
  assign fetch_done = stage.valid && stage.is_fetch;
  assign res_valid  = stage.valid;

  always_comb begin
    if (stage.is_fetch) begin
      res.fetch_pc     = stage.pc;
      res.instr_code   = code;
      res.instr_func   = func;
      res.reg_a        = regs ? fb[1][7:4] : REG_NONE;
      res.reg_b        = regs ? fb[1][3:0] : REG_NONE;
      res.const_value  = cval;
      res.next_seq_pc  = next_pc;
      res.predicted_pc = pred;
    end else begin
      res = '0;
    end
  end

  // held prediction with bypass for the fetch right behind
  assign held_nxt = fetch_done ? pred : held_r;
  assign pred_now = held_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

endmodule

@@ hw/rtl/y86f_queue.sv @@
// y86f_queue: small result fifo between the decode stage and the output port
// depends on y86f_pkg

module y86f_queue
  import y86f_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  result_t           push_data,
  input  logic              pop_ready,
  output logic              head_valid,
  output result_t           head_data,
  output logic [QCNT_W-1:0] count
);

  result_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r;
  logic [QPTR_W-1:0]   rp_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;
  logic                pop;

  assign head_valid = (cnt_r != '0);
  assign head_data  = entry_r[rp_r];
  assign count      = cnt_r;
  assign pop        = head_valid && pop_ready;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and occupancy count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // upstream credit must never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < QCNT_W'(QDEPTH)) || pop)
    else $error("result queue overflow");

  // occupancy stays within depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

  // a lone transfer out lowers the count by one
  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("result queue count did not drop on transfer out");
`endif

endmodule
